[rtl/core/pcbp_pkg.sv]
package pcbp_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int ADDR_W = $clog2(MAX_VERTICES);
   localparam int CNT_W = 7;
   localparam int DIST_W = 35;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic               operation;
      logic [5:0]         vertex_index;
      logic signed [15:0] coord_x;
      logic signed [15:0] coord_y;
      logic signed [15:0] edge_dir_x;
      logic signed [15:0] edge_dir_y;
      logic [15:0]        edge_length;
      logic signed [15:0] edge_normal_x;
      logic signed [15:0] edge_normal_y;
   } req_type;

   typedef struct packed {
      logic               found;
      logic signed [15:0] closest_x;
      logic signed [15:0] closest_y;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic [DIST_W-1:0]  distance_squared;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic [15:0]        len;
      logic signed [15:0] nrm_x;
      logic signed [15:0] nrm_y;
   } vertex_entry_type;

   localparam int ENTRY_W = $bits(vertex_entry_type);

   typedef struct packed {
      logic              load;
      logic              start;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              edge_ready;
   } dp_cmd_type;

   typedef struct packed {
      logic busy;
   } dp_status_type;

endpackage

[rtl/core/pcbp_ram.sv]
module pcbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/pcbp_datapath.sv]
module pcbp_datapath import pcbp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output rsp_type       rsp_data
);

   vertex_entry_type wr_entry, rd_entry;

   assign wr_entry = '{pos_x: req_data.coord_x, pos_y: req_data.coord_y,
                       dir_x: req_data.edge_dir_x, dir_y: req_data.edge_dir_y,
                       len: req_data.edge_length, nrm_x: req_data.edge_normal_x,
                       nrm_y: req_data.edge_normal_y};

   pcbp_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_VERTICES)) u_store (
      .clock (clock),
      .we    (cmd.load),
      .waddr (req_data.vertex_index[ADDR_W-1:0]),
      .wdata (wr_entry),
      .re    (cmd.rd_en),
      .raddr (cmd.rd_addr),
      .rdata (rd_entry)
   );

   // Query point.
   logic signed [15:0] px_ff, py_ff;

   // Read return and three-entry window (previous, current, next).
   logic rd_valid_ff, rd_edge_ff, win_valid_ff;
   vertex_entry_type prev_ff, cur_ff, next_ff;

   // Stage 1.
   logic               v1_ff;
   logic signed [32:0] s1_mx_ff, s1_my_ff;
   vertex_entry_type   s1_ent_ff;
   logic signed [15:0] s1_bx_ff, s1_by_ff, s1_apx_ff, s1_apy_ff, s1_anx_ff, s1_any_ff;
   // Stage 2.
   logic               v2_ff, s2_neg_ff, s2_over_ff;
   logic signed [33:0] s2_d_ff;
   vertex_entry_type   s2_ent_ff;
   logic signed [15:0] s2_bx_ff, s2_by_ff, s2_apx_ff, s2_apy_ff, s2_anx_ff, s2_any_ff;
   // Stage 3.
   logic               v3_ff, s3_neg_ff, s3_over_ff;
   logic signed [49:0] s3_pcx_ff, s3_pcy_ff;
   vertex_entry_type   s3_ent_ff;
   logic signed [15:0] s3_bx_ff, s3_by_ff, s3_apx_ff, s3_apy_ff, s3_anx_ff, s3_any_ff;
   // Stage 4.
   logic               v4_ff;
   logic signed [15:0] s4_cx_ff, s4_cy_ff, s4_nx_ff, s4_ny_ff;
   // Stage 5.
   logic               v5_ff;
   logic signed [33:0] s5_sqx_ff, s5_sqy_ff;
   logic signed [15:0] s5_cx_ff, s5_cy_ff, s5_nx_ff, s5_ny_ff;
   // Running best.
   rsp_type best_ff;

   function automatic logic signed [15:0] avg16(logic signed [15:0] a, logic signed [15:0] b);
      logic signed [16:0] s;
      s = 17'(a) + 17'(b);
      return s[16:1];
   endfunction

   function automatic logic signed [15:0] proj(logic signed [15:0] a, logic signed [49:0] p);
      logic signed [49:0] r;
      logic signed [21:0] c;
      r = p + 50'sd134217728;
      c = 22'(a) + r[49:28];
      if (c > 22'sd32767) begin
         return 16'sh7fff;
      end else if (c < -22'sd32768) begin
         return 16'sh8000;
      end
      return c[15:0];
   endfunction

   logic signed [16:0] dx, dy, ex, ey;
   logic signed [33:0] d_sum, len_lim;
   logic [DIST_W-1:0]  cand_dsq;

   assign dx = 17'(px_ff) - 17'(cur_ff.pos_x);
   assign dy = 17'(py_ff) - 17'(cur_ff.pos_y);
   assign d_sum = 34'(s1_mx_ff) + 34'(s1_my_ff);
   assign len_lim = $signed({4'b0, s1_ent_ff.len, 14'b0});
   assign ex = 17'(s4_cx_ff) - 17'(px_ff);
   assign ey = 17'(s4_cy_ff) - 17'(py_ff);
   assign cand_dsq = DIST_W'(s5_sqx_ff[32:0]) + DIST_W'(s5_sqy_ff[32:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         win_valid_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         best_ff <= '0;
      end else begin
         rd_valid_ff  <= cmd.rd_en;
         win_valid_ff <= rd_valid_ff & rd_edge_ff;
         v1_ff <= win_valid_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         if (cmd.start) begin
            best_ff <= '0;
         end else if (v5_ff && (!best_ff.found || cand_dsq < best_ff.distance_squared)) begin
            best_ff <= '{found: 1'b1, closest_x: s5_cx_ff, closest_y: s5_cy_ff,
                         normal_x: s5_nx_ff, normal_y: s5_ny_ff, distance_squared: cand_dsq};
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_edge_ff <= cmd.edge_ready;
      if (cmd.start) begin
         px_ff <= req_data.coord_x;
         py_ff <= req_data.coord_y;
      end
      if (rd_valid_ff) begin
         prev_ff <= cur_ff;
         cur_ff  <= next_ff;
         next_ff <= rd_entry;
      end
      // Stage 1: offsets to the edge start and the two products of the dot product.
      s1_mx_ff  <= dx * cur_ff.dir_x;
      s1_my_ff  <= dy * cur_ff.dir_y;
      s1_ent_ff <= cur_ff;
      s1_bx_ff  <= next_ff.pos_x;
      s1_by_ff  <= next_ff.pos_y;
      s1_apx_ff <= avg16(cur_ff.nrm_x, prev_ff.nrm_x);
      s1_apy_ff <= avg16(cur_ff.nrm_y, prev_ff.nrm_y);
      s1_anx_ff <= avg16(cur_ff.nrm_x, next_ff.nrm_x);
      s1_any_ff <= avg16(cur_ff.nrm_y, next_ff.nrm_y);
      // Stage 2: projection length and clamp decision.
      s2_d_ff    <= d_sum;
      s2_neg_ff  <= d_sum[33];
      s2_over_ff <= d_sum > len_lim;
      s2_ent_ff  <= s1_ent_ff;
      {s2_bx_ff, s2_by_ff, s2_apx_ff, s2_apy_ff, s2_anx_ff, s2_any_ff} <=
         {s1_bx_ff, s1_by_ff, s1_apx_ff, s1_apy_ff, s1_anx_ff, s1_any_ff};
      // Stage 3: scale the unit vector by the projection length.
      s3_pcx_ff  <= s2_d_ff * s2_ent_ff.dir_x;
      s3_pcy_ff  <= s2_d_ff * s2_ent_ff.dir_y;
      s3_neg_ff  <= s2_neg_ff;
      s3_over_ff <= s2_over_ff;
      s3_ent_ff  <= s2_ent_ff;
      {s3_bx_ff, s3_by_ff, s3_apx_ff, s3_apy_ff, s3_anx_ff, s3_any_ff} <=
         {s2_bx_ff, s2_by_ff, s2_apx_ff, s2_apy_ff, s2_anx_ff, s2_any_ff};
      // Stage 4: candidate point and its normal.
      if (s3_neg_ff) begin
         s4_cx_ff <= s3_ent_ff.pos_x;
         s4_cy_ff <= s3_ent_ff.pos_y;
         s4_nx_ff <= s3_apx_ff;
         s4_ny_ff <= s3_apy_ff;
      end else if (s3_over_ff) begin
         s4_cx_ff <= s3_bx_ff;
         s4_cy_ff <= s3_by_ff;
         s4_nx_ff <= s3_anx_ff;
         s4_ny_ff <= s3_any_ff;
      end else begin
         s4_cx_ff <= proj(s3_ent_ff.pos_x, s3_pcx_ff);
         s4_cy_ff <= proj(s3_ent_ff.pos_y, s3_pcy_ff);
         s4_nx_ff <= s3_ent_ff.nrm_x;
         s4_ny_ff <= s3_ent_ff.nrm_y;
      end
      // Stage 5: squared offsets.
      s5_sqx_ff <= ex * ex;
      s5_sqy_ff <= ey * ey;
      {s5_cx_ff, s5_cy_ff, s5_nx_ff, s5_ny_ff} <= {s4_cx_ff, s4_cy_ff, s4_nx_ff, s4_ny_ff};
   end

   assign status.busy = rd_valid_ff | win_valid_ff | v1_ff | v2_ff | v3_ff | v4_ff | v5_ff;
   assign rsp_data = best_ff;

endmodule

[rtl/core/pcbp_ctrl.sv]
module pcbp_ctrl import pcbp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [CNT_W-1:0] count,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_op,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  dp_status_type    status,
   output dp_cmd_type       cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_RESP  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic             accept, last_rd;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign accept = req_valid & req_ready;
   assign last_rd = (k_ff == count + CNT_W'(1));

   always_comb begin
      cmd.load = accept & (req_op == OP_LOAD);
      cmd.start = accept & (req_op == OP_QUERY);
      cmd.rd_en = (state_ff == ST_SCAN);
      cmd.edge_ready = (k_ff >= CNT_W'(2));
      if (k_ff == '0) begin
         cmd.rd_addr = ADDR_W'(count - CNT_W'(1));
      end else if (last_rd) begin
         cmd.rd_addr = '0;
      end else begin
         cmd.rd_addr = ADDR_W'(k_ff - CNT_W'(1));
      end
   end

   always_comb begin
      state_in = state_ff;
      k_in = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            k_in = '0;
            if (cmd.start) begin
               state_in = (count == '0) ? ST_RESP : ST_SCAN;
            end
         end
         ST_SCAN: begin
            k_in = k_ff + CNT_W'(1);
            if (last_rd) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.busy) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff <= '0;
      end else begin
         state_ff <= state_in;
         k_ff <= k_in;
      end
   end

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (k_ff <= count + CNT_W'(1)))
      else $error("edge read counter ran past the window end");

   a_resp_idle_dp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP) |-> !status.busy)
      else $error("result offered while the datapath still works");

   a_empty_query: assert property (@(posedge clock) disable iff (reset)
      (cmd.start && count == '0) |=> (state_ff == ST_RESP))
      else $error("empty polygon query did not answer at once");

endmodule

[rtl/core/polygon_closest_boundary_point_top.sv]
// Channel   | Handshake              | Payload
// request   | req_valid / req_ready  | req_data (req_type): load or query item
// response  | rsp_valid / rsp_ready  | rsp_data (rsp_type): one per query
// registers | psel, penable, pwrite  | paddr, pwdata, prdata; pready tied high
//
// A load transfer writes one vertex entry; loads can follow back to back.
// A query reads the store vertex_count + 2 times, wrapping around the polygon, then
// waits while the edge pipeline drains before the response is offered; no new request is
// taken meanwhile. An empty polygon answers in the next cycle.
// Reset is synchronous and active high; vertex_count returns to zero.
// A stalled response holds the block; no new request is taken until it leaves.
module polygon_closest_boundary_point_top import pcbp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // The only register lives at offset zero, so every address decodes to it.
   logic [CNT_W-1:0] vcount_ff, vcount_in;
   logic [CNT_W-1:0] count;
   logic             csr_wr;
   dp_cmd_type       cmd;
   dp_status_type    status;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;
   assign vcount_in = csr_wr ? pwdata[CNT_W-1:0] : vcount_ff;
   assign prdata = {{(32 - CNT_W){1'b0}}, vcount_ff} | {30'b0, paddr & 2'b00};

   // A count above the store depth walks the whole store.
   assign count = (vcount_ff > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vcount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= '0;
      end else begin
         vcount_ff <= vcount_in;
      end
   end

   // The controller sequences the edge reads; the datapath holds the store,
   // the three-entry window and the per-edge pipeline with the running best.
   pcbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .count     (count),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_data.operation),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pcbp_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
